[sv/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key/value cache
// Word layouts of the request and response channels, register map and
// default sizes of the entry store.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	// default sizes of the entry store
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// field widths of the channel words
	localparam int KEY_W   = 32;
	localparam int VALUE_W = 32;

	// configuration register map
	localparam int ADDR_W = 3;
	localparam int CAP_W  = 5;
	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

	// request modes
	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_SET = 1'b1;

	// value returned on a get miss and on every set
	localparam logic signed [VALUE_W-1:0] MISS_VALUE = '1;

	// request word
	typedef struct packed {
		logic                      mode;
		logic [KEY_W-1:0]          key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	// response word
	typedef struct packed {
		logic                      hit;
		logic signed [VALUE_W-1:0] read_value;
		logic                      evicted;
	} rsp_t;

endpackage

[sv/lru_key_value_cache_top.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key/value cache
// Least-recently-set replacement, parallel key compare, one request a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// usage
// - request channel in_valid / in_stall / in_word carries mode, key, value;
//   a word is taken at a clock edge with in_valid high and in_stall low
// - response channel out_valid / out_stall / out_word returns one word per
//   request: hit, read_value (-1 on a miss or a set) and evicted
// - the request is registered, looked up and the store updated when it
//   advances, and the response lands in the output register; throughput
//   is one request per cycle while the output is not stalled, set by the
//   combinational compare across all entries and the rank update
// - a request sees every store update of the request before it
// - while out_stall holds a full output register the request register
//   stays put and in_stall rises; the output word does not change
// - reset clears all valid bits, ranks, the fill count and sets capacity
//   to 16; no clearing pass is needed, keys and values are left as they are
// - the user writes capacity through the apb port only while the cache is idle;
//   the block does not enforce it; zero acts as one, values above the store size act as the store size
module lru_key_value_cache_top #(
	parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lkvc_pkg::req_t              in_word,
	// response channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output lkvc_pkg::rsp_t              out_word,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = ((CNT_W > lkvc_pkg::CAP_W) ? CNT_W : lkvc_pkg::CAP_W) + 1;
	localparam int VW     = lkvc_pkg::VALUE_W;

	// entry store
	logic [KEY_BITS-1:0]   key_q   [ENTRIES];
	logic [VALUE_BITS-1:0] value_q [ENTRIES];
	logic [RANK_W-1:0]     rank_q  [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      fill_q;
	logic [lkvc_pkg::CAP_W-1:0] capacity_q;

	// request register and output register
	logic           valid_s1;
	lkvc_pkg::req_t req_s1;
	logic           out_valid_q;
	lkvc_pkg::rsp_t rsp_q;

	// lookup signals
	logic                     adv;
	logic                     is_set;
	logic [KEY_BITS+31:0]     key_ext;
	logic [KEY_BITS-1:0]      key_cmp;
	logic [VALUE_BITS+31:0]   val_ext;
	logic [VALUE_BITS-1:0]    val_store;
	logic [ENTRIES-1:0]       match;
	logic [ENTRIES-1:0]       free_vec;
	logic [ENTRIES-1:0]       free_oh;
	logic [ENTRIES-1:0]       victim;
	logic [ENTRIES-1:0]       wr_oh;
	logic [ENTRIES-1:0]       age;
	logic                     hit;
	logic [RANK_W-1:0]        hit_rank;
	logic [VALUE_BITS-1:0]    hit_value;
	logic [VALUE_BITS+VW-1:0] rv_ext;
	logic [RANK_W-1:0]        lru_rank;
	logic [RANK_W-1:0]        age_limit;
	logic [CMP_W-1:0]         cap_ext;
	logic [CMP_W-1:0]         cap_eff;
	logic                     do_fill;
	logic                     do_write;
	logic                     cfg_wr;
	lkvc_pkg::rsp_t           rsp_d;

	// handshake
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_word  = rsp_q;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_word;
		end
	end

	// key and value at store width
	assign key_ext   = {{KEY_BITS{1'b0}}, req_s1.key};
	assign key_cmp   = key_ext[KEY_BITS-1:0];
	assign val_ext   = {{VALUE_BITS{1'b0}}, req_s1.value};
	assign val_store = val_ext[VALUE_BITS-1:0];
	assign is_set    = (req_s1.mode == lkvc_pkg::MODE_SET);

	// parallel compare and one-hot readout
	always_comb begin
		hit_rank  = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i]  = valid_q[i] && (key_q[i] == key_cmp);
			hit_rank  = hit_rank | (rank_q[i] & {RANK_W{match[i]}});
			hit_value = hit_value | (value_q[i] & {VALUE_BITS{match[i]}});
		end
	end
	assign hit = |match;

	// first free entry
	assign free_vec = ~valid_q;
	assign free_oh  = free_vec & (~free_vec + ENTRIES'(1));

	// effective capacity against fill count
	assign cap_ext = CMP_W'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			cap_eff = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			cap_eff = CMP_W'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end
	assign do_fill = (CMP_W'(fill_q) < cap_eff);

	// least recent entry holds rank fill_count-1
	assign lru_rank = RANK_W'(fill_q - CNT_W'(1));
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim[i] = valid_q[i] && (rank_q[i] == lru_rank);
		end
	end

	// entry to write and entries that age
	assign do_write  = adv && is_set;
	assign wr_oh     = hit ? match : (do_fill ? free_oh : victim);
	assign age_limit = hit ? hit_rank : lru_rank;
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			age[i] = valid_q[i] && ((!hit && do_fill) || (rank_q[i] < age_limit));
		end
	end

	// store control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (do_write) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_oh[i]) begin
					valid_q[i] <= 1'b1;
					rank_q[i]  <= '0;
				end else if (age[i]) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			if (!hit && do_fill) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// store keys and values
	always_ff @(posedge clk) begin
		if (do_write) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_oh[i]) begin
					key_q[i]   <= key_cmp;
					value_q[i] <= val_store;
				end
			end
		end
	end

	// response word
	assign rv_ext = {{VW{hit_value[VALUE_BITS-1]}}, hit_value};
	always_comb begin
		rsp_d.hit     = hit;
		rsp_d.evicted = is_set && !hit && !do_fill;
		if (!is_set && hit) begin
			rsp_d.read_value = rv_ext[VW-1:0];
		end else begin
			rsp_d.read_value = lkvc_pkg::MISS_VALUE;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAPACITY_RESET;
		end else if (cfg_wr && (paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[lkvc_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == lkvc_pkg::REG_CAPACITY) ? 32'(capacity_q) : '0;

`ifndef SYNTHESIS
	// valid entries and fill count agree
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(fill_q))
		else $error("fill count differs from number of valid entries");

	// a key is held by at most one entry
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match))
		else $error("key present in more than one entry");

	// an eviction never happens on a hit
	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_q.evicted) |-> !rsp_q.hit)
		else $error("eviction reported together with a hit");

	// a set that misses while full always finds its victim
	a_victim_found: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_set && !hit && !do_fill) |-> $onehot(victim))
		else $error("no single least recent entry to evict");
`endif

endmodule

[sim/lkvc_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lkvc_checker: response checker of the lru key/value cache
// Watches the request, response and apb channels, keeps its own copy of the
// entry store, ranks and capacity register, predicts one response word per
// accepted request and compares each accepted response word in order.
// ----------------------------------------------------------------------------
module lkvc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  lkvc_pkg::req_t              in_word,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  lkvc_pkg::rsp_t              out_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          pending,
	output int                          fail_count
);

	localparam int SLOTS = lkvc_pkg::ENTRIES_DEF;

	// shadow of the entry store
	logic [lkvc_pkg::KEY_W-1:0]   slot_key   [SLOTS];
	logic [lkvc_pkg::VALUE_W-1:0] slot_value [SLOTS];
	bit                           slot_used  [SLOTS];
	int unsigned                  slot_age   [SLOTS];
	int unsigned                  used_count;
	logic [lkvc_pkg::CAP_W-1:0]   cap_reg;

	// responses still owed by the cache
	lkvc_pkg::rsp_t rsp_q[$];
	lkvc_pkg::rsp_t want_word;
	lkvc_pkg::rsp_t next_word;

	assign pending = rsp_q.size();

	// every used entry more recent than limit gets one step older
	task automatic age_entries(input int unsigned limit);
		for (int i = 0; i < SLOTS; i++)
			if (slot_used[i] && slot_age[i] < limit)
				slot_age[i]++;
	endtask

	// look up one request word, update the shadow store, build the response
	task automatic lookup_and_update(input lkvc_pkg::req_t req, output lkvc_pkg::rsp_t rsp);
		int          found;
		int          slot;
		int unsigned oldest;
		bit          any;
		int unsigned cap;
		found = -1;
		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && slot_used[i] && slot_key[i] == req.key)
				found = i;
		rsp.hit        = (found >= 0);
		rsp.read_value = lkvc_pkg::MISS_VALUE;
		rsp.evicted    = 1'b0;
		if (req.mode == lkvc_pkg::MODE_GET) begin
			if (found >= 0)
				rsp.read_value = slot_value[found];
		end else if (found >= 0) begin
			slot_value[found] = req.value;
			age_entries(slot_age[found]);
			slot_age[found] = 0;
		end else begin
			// zero acts as one, anything above the store size as the store size
			cap = cap_reg;
			if (cap == 0)
				cap = 1;
			if (cap > SLOTS)
				cap = SLOTS;
			slot = 0;
			if (used_count < cap) begin
				slot = -1;
				for (int i = 0; i < SLOTS; i++)
					if (slot < 0 && !slot_used[i])
						slot = i;
				age_entries(32'hFFFF_FFFF);
				used_count++;
			end else begin
				// evict the least recent entry
				oldest = 0;
				any    = 1'b0;
				for (int i = 0; i < SLOTS; i++)
					if (slot_used[i] && (!any || slot_age[i] > oldest)) begin
						oldest = slot_age[i];
						slot   = i;
						any    = 1'b1;
					end
				age_entries(oldest);
				rsp.evicted = 1'b1;
			end
			slot_used[slot]  = 1'b1;
			slot_key[slot]   = req.key;
			slot_value[slot] = req.value;
			slot_age[slot]   = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				slot_used[i]  = 1'b0;
				slot_age[i]   = 0;
				slot_key[i]   = '0;
				slot_value[i] = '0;
			end
			used_count = 0;
			cap_reg    = lkvc_pkg::CAPACITY_RESET;
			fail_count = 0;
			rsp_q.delete();
		end else begin
			// register reads return the stored capacity
			if (psel && penable && !pwrite && pready &&
					paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY) begin
				if (prdata !== {{(32-lkvc_pkg::CAP_W){1'b0}}, cap_reg}) begin
					$error("capacity: expected %0h, actual %0h", cap_reg, prdata);
					fail_count++;
				end
			end
			// register writes, unmapped addresses are dropped
			if (psel && penable && pwrite && pready &&
					paddr[lkvc_pkg::ADDR_W-1:2] == lkvc_pkg::REG_CAPACITY)
				cap_reg = pwdata[lkvc_pkg::CAP_W-1:0];

			// response word against the oldest prediction
			if (out_valid && !out_stall) begin
				if (rsp_q.size() == 0) begin
					$error("response word with nothing outstanding");
					fail_count++;
				end else begin
					want_word = rsp_q.pop_front();
					if (out_word.hit !== want_word.hit) begin
						$error("hit: expected %0b, actual %0b", want_word.hit, out_word.hit);
						fail_count++;
					end
					if (out_word.read_value !== want_word.read_value) begin
						$error("read_value: expected %0h, actual %0h",
							want_word.read_value, out_word.read_value);
						fail_count++;
					end
					if (out_word.evicted !== want_word.evicted) begin
						$error("evicted: expected %0b, actual %0b",
							want_word.evicted, out_word.evicted);
						fail_count++;
					end
				end
			end

			// request word into the shadow store
			if (in_valid && !in_stall) begin
				lookup_and_update(in_word, next_word);
				rsp_q.push_back(next_word);
			end
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the lru key/value cache
// Drives directed and random get/set words under several capacity settings
// with random gaps and stalls, a long output hold-off and drain pauses; the
// checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 175;
	localparam int POOL_SIZE     = 24;
	localparam int SETTLE_CYCLES = 4;
	localparam int KW            = lkvc_pkg::KEY_W;
	localparam int VW            = lkvc_pkg::VALUE_W;
	localparam int CW            = lkvc_pkg::CAP_W;
	localparam int AW            = lkvc_pkg::ADDR_W;
	localparam logic [AW-1:0] ADDR_CAPACITY = {lkvc_pkg::REG_CAPACITY, 2'b00};
	localparam logic [AW-1:0] ADDR_UNMAPPED = AW'(4);

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	lkvc_pkg::req_t    in_word  = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	lkvc_pkg::rsp_t    out_word;
	logic              psel     = 1'b0;
	logic              penable  = 1'b0;
	logic              pwrite   = 1'b0;
	logic [AW-1:0]     paddr    = '0;
	logic [31:0]       pwdata   = '0;
	logic [31:0]       prdata;
	logic              pready;
	int                pending;
	int                fail_count;

	// idling controls shared by the sender and the receiver
	bit quiet    = 1'b0;
	bit hold_req = 1'b0;

	logic [KW-1:0] key_pool [POOL_SIZE];
	int            pool_span = POOL_SIZE;
	int            cycle_count = 0;

	always #5 clk = ~clk;

	lru_key_value_cache_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	lkvc_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.pending    (pending),
		.fail_count (fail_count)
	);

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	// response side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= !quiet && ($urandom_range(99) < 21);
		end
	end

	// offer one request word and wait until it is taken
	task automatic send_word(input logic mode_i, input logic [KW-1:0] key_i,
			input logic [VW-1:0] value_i);
		lkvc_pkg::req_t w;
		w.mode  = mode_i;
		w.key   = key_i;
		w.value = value_i;
		// each cycle idles on its own draw
		while (!quiet && !hold_req && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// random request word, mostly on a small key set so hits and evictions happen
	task automatic send_random_word();
		int            pick;
		logic [KW-1:0] k;
		pick = $urandom_range(99);
		k    = key_pool[$urandom_range(pool_span - 1)];
		if (pick >= 90)
			k = $urandom;
		else if (pick >= 80)
			k = k ^ (KW'(1) << $urandom_range(KW - 1));
		send_word(logic'($urandom_range(1)), k, $urandom);
	endtask

	// stop offering and wait for every outstanding response word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one apb transfer: setup cycle, then access until pready
	task automatic apb_access(input bit wr, input logic [AW-1:0] addr,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		logic [CW-1:0] cap;
		logic [31:0]   upper;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// capacity of one: a new key evicts the only entry
		apb_access(1'b1, ADDR_CAPACITY, 32'hFFFF_FFE1);
		apb_access(1'b0, ADDR_CAPACITY, '0);
		send_word(lkvc_pkg::MODE_GET, '0, $urandom);
		send_word(lkvc_pkg::MODE_SET, '0, 32'h7FFF_FFFF);
		send_word(lkvc_pkg::MODE_SET, '1, 32'h8000_0000);
		send_word(lkvc_pkg::MODE_GET, '0, '0);
		send_word(lkvc_pkg::MODE_GET, '1, '1);
		drain();

		// capacity zero acts as one, unmapped write is dropped
		apb_access(1'b1, ADDR_CAPACITY, '0);
		apb_access(1'b1, ADDR_UNMAPPED, 32'd3);
		apb_access(1'b0, ADDR_CAPACITY, '0);
		send_word(lkvc_pkg::MODE_SET, 32'd5, '0);
		send_word(lkvc_pkg::MODE_GET, 32'd5, $urandom);
		drain();

		// capacity above the store size saturates: fill, update, evict oldest
		apb_access(1'b1, ADDR_CAPACITY, 32'd31);
		for (int k = 1; k <= 15; k++)
			send_word(lkvc_pkg::MODE_SET, KW'(32'h10 + k), $urandom);
		send_word(lkvc_pkg::MODE_SET, 32'h11, '1);
		send_word(lkvc_pkg::MODE_SET, 32'h100, 32'd1);
		send_word(lkvc_pkg::MODE_GET, 32'd5, '0);
		drain();

		// key set for the random part
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = '0;
		key_pool[1] = '1;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: cap = CW'(1);
				1: cap = CW'(16);
				2: cap = '0;
				3: cap = '1;
				4: cap = CW'(2);
				6: cap = CW'(15);
				default: cap = CW'($urandom_range(31));
			endcase
			upper = $urandom;
			apb_access(1'b1, ADDR_CAPACITY, {upper[31:CW], cap});
			apb_access(1'b0, ADDR_CAPACITY, '0);
			pool_span = $urandom_range(POOL_SIZE, 4);
			quiet     = (ph == 3);
			if (ph == 5)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// pause until every response word is back, then carry on
				if (ph == 6 && n == PHASE_WORDS / 2)
					drain();
				send_random_word();
			end
			drain();
		end
		quiet = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
sv/lkvc_pkg.sv
sv/lru_key_value_cache_top.sv
sim/lkvc_checker.sv
sim/tb_top.sv
